// ===== rtl/preemptive_priority_scheduler_top_macros.svh =====
// Assertion macros for the preemptive priority scheduler.
// Taken in by the top level; relies on nothing else.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_TOP_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPS_CHK_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PPS_CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pps_pkg.sv =====
// Shared types and codes of the preemptive priority scheduler.
// No dependencies; used by pps_table and the top level.
package pps_pkg;

  localparam int TIME_W = 22;
  localparam logic [TIME_W-1:0] TIME_MAX = 22'h3FFFFF;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [2:0] ST_LOADED  = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_RAN     = 3'd2;
  localparam logic [2:0] ST_IDLE    = 3'd3;
  localparam logic [2:0] ST_ALLDONE = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;

  typedef struct packed {
    logic [15:0]       id;
    logic [15:0]       arrival;
    logic [15:0]       burst;
    logic [7:0]        prio;
    logic [15:0]       remaining;
    logic              started;
    logic              done;
    logic [TIME_W-1:0] response;
  } entry_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [TIME_W-1:0] slot_start_time;
    logic [15:0]       running_id;
    logic              finished;
    logic [TIME_W-1:0] completion;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic [TIME_W-1:0] response;
  } res_t;

endpackage

// ===== rtl/pps_table.sv =====
// Task table memory: one write port, one registered read port.
// Depends on pps_pkg for the entry layout.
module pps_table #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  pps_pkg::entry_t wr_data,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output pps_pkg::entry_t rd_data
);

  pps_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/preemptive_priority_scheduler_top.sv =====
// Preemptive priority scheduler: task table, tick sequencer, result register.
// Depends on pps_pkg, pps_table and preemptive_priority_scheduler_top_macros.svh.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------
//   input   | in_valid/in_ready  | opcode, task_id, arrival, burst, prio
//   output  | out_valid/out_ready| status, slot_start_time, running_id,
//           |                    | finished, completion, turnaround, waiting,
//           |                    | response
//
// Clear, load, full, all-done: the transfer registers the result, then emits.
// Tick: the table is scanned one entry per cycle through its single read port;
// an idle tick then emits, a running task passes update, turnaround and finish.
// Synchronous active-high reset empties the table and zeroes time at once.
// A new item is taken while an earlier result still waits in the output
// register; the sequencer holds its next result until that register frees.
`include "preemptive_priority_scheduler_top_macros.svh"

module preemptive_priority_scheduler_top #(
  parameter int MAX_TASKS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [15:0] task_id,
  input  logic [15:0] arrival,
  input  logic [15:0] burst,
  input  logic [7:0]  prio,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [21:0] slot_start_time,
  output logic [15:0] running_id,
  output logic        finished,
  output logic [21:0] completion,
  output logic [21:0] turnaround,
  output logic [21:0] waiting,
  output logic [21:0] response
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int TW = pps_pkg::TIME_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_TAT  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]      state;
  logic [CW-1:0]   entry_count;
  logic [CW-1:0]   done_count;
  logic [TW-1:0]   now;
  logic [CW-1:0]   issue_idx;
  logic            cmp_valid;
  logic [IW-1:0]   cmp_slot;
  logic            best_found;
  logic [IW-1:0]   best_slot;
  pps_pkg::entry_t best;
  logic [TW-1:0]   tat;
  pps_pkg::res_t   res;

  logic            accept;
  logic            out_free;
  logic            table_full;
  logic            scan_issue;
  logic            eligible;
  logic            better;
  logic [TW-1:0]   now_adv;
  logic [TW-1:0]   burst_ext;
  pps_pkg::entry_t rd_data;
  pps_pkg::entry_t wr_data;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  pps_pkg::res_t   res_init;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign table_full = (entry_count >= CW'(MAX_TASKS));
  assign scan_issue = (state == S_SCAN) && (issue_idx < entry_count);
  assign now_adv    = (now == pps_pkg::TIME_MAX) ? now : now + TW'(1);
  assign burst_ext  = TW'(best.burst);

  // Shared compare unit: one table entry against the current best per cycle.
  assign eligible = !rd_data.done && (rd_data.remaining != 16'd0) &&
                    (TW'(rd_data.arrival) <= now);
  assign better   = !best_found || (rd_data.prio < best.prio) ||
                    ((rd_data.prio == best.prio) && (rd_data.arrival < best.arrival));

  // Result fields known at transfer; a tick that scans overwrites the status later.
  always_comb begin
    res_init                 = '0;
    res_init.slot_start_time = now;
    case (opcode)
      pps_pkg::OP_CLEAR: begin
        res_init.status          = pps_pkg::ST_CLEARED;
        res_init.slot_start_time = '0;
      end
      pps_pkg::OP_LOAD: begin
        res_init.status = table_full ? pps_pkg::ST_FULL : pps_pkg::ST_LOADED;
      end
      default: begin
        res_init.status = pps_pkg::ST_ALLDONE;
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = entry_count[IW-1:0];
    wr_data = best;
    if (accept && (opcode == pps_pkg::OP_LOAD) && !table_full) begin
      wr_en             = 1'b1;
      wr_data.id        = task_id;
      wr_data.arrival   = arrival;
      wr_data.burst     = burst;
      wr_data.prio      = prio;
      wr_data.remaining = burst;
      wr_data.started   = 1'b0;
      wr_data.done      = (burst == 16'd0);
      wr_data.response  = '0;
    end else if (state == S_FIN) begin
      wr_en        = 1'b1;
      wr_addr      = best_slot;
      wr_data.done = (best.remaining == 16'd0);
    end
  end

  pps_table #(
    .DEPTH(MAX_TASKS),
    .AW   (IW)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (scan_issue),
    .rd_addr(issue_idx[IW-1:0]),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      done_count  <= '0;
      now         <= '0;
      issue_idx   <= '0;
      cmp_valid   <= 1'b0;
      best_found  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if ((state == S_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res <= res_init;
            case (opcode)
              pps_pkg::OP_CLEAR: begin
                entry_count <= '0;
                done_count  <= '0;
                now         <= '0;
                state       <= S_EMIT;
              end
              pps_pkg::OP_LOAD: begin
                if (!table_full) begin
                  entry_count <= entry_count + CW'(1);
                  if (burst == 16'd0) begin
                    done_count <= done_count + CW'(1);
                  end
                end
                state <= S_EMIT;
              end
              pps_pkg::OP_TICK: begin
                if (done_count >= entry_count) begin
                  state <= S_EMIT;
                end else begin
                  issue_idx  <= '0;
                  cmp_valid  <= 1'b0;
                  best_found <= 1'b0;
                  state      <= S_SCAN;
                end
              end
              default: begin
                // unused code: no result, no state change
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_issue) begin
            issue_idx <= issue_idx + CW'(1);
          end
          cmp_valid <= scan_issue;
          cmp_slot  <= issue_idx[IW-1:0];
          if (cmp_valid && eligible && better) begin
            best       <= rd_data;
            best_slot  <= cmp_slot;
            best_found <= 1'b1;
          end
          if (!scan_issue && !cmp_valid) begin
            if (best_found) begin
              state <= S_UPD;
            end else begin
              now        <= now_adv;
              res.status <= pps_pkg::ST_IDLE;
              state      <= S_EMIT;
            end
          end
        end
        S_UPD: begin
          if (!best.started) begin
            best.started  <= 1'b1;
            best.response <= now - TW'(best.arrival);
          end
          best.remaining <= best.remaining - 16'd1;
          now            <= now_adv;
          state          <= S_TAT;
        end
        S_TAT: begin
          tat   <= now - TW'(best.arrival);
          state <= S_FIN;
        end
        S_FIN: begin
          res.status     <= pps_pkg::ST_RAN;
          res.running_id <= best.id;
          if (best.remaining == 16'd0) begin
            done_count     <= done_count + CW'(1);
            res.finished   <= 1'b1;
            res.completion <= now;
            res.turnaround <= tat;
            res.waiting    <= (tat >= burst_ext) ? tat - burst_ext : '0;
            res.response   <= best.response;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          // hold the result until the output register frees
          if (out_free) begin
            status          <= res.status;
            slot_start_time <= res.slot_start_time;
            running_id      <= res.running_id;
            finished        <= res.finished;
            completion      <= res.completion;
            turnaround      <= res.turnaround;
            waiting         <= res.waiting;
            response        <= res.response;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PPS_CHK_NOW(a_done_bound, clk, rst, 1'b1, done_count <= entry_count,
               "done count above entry count")
  `PPS_CHK_NOW(a_cmp_range, clk, rst, (state == S_SCAN) && cmp_valid,
               CW'(cmp_slot) < entry_count, "compared slot beyond table fill")
  `PPS_CHK_NOW(a_upd_winner, clk, rst, state == S_UPD,
               best_found && (best.remaining != 16'd0), "update without runnable winner")
  `PPS_CHK_NEXT(a_emit, clk, rst, (state == S_EMIT) && out_free,
                out_valid && (state == S_IDLE), "result not delivered to output")

endmodule
